@@ design/mcfb_pkg.sv @@
package mcfb_pkg;

  // command kinds
  localparam logic [3:0] KIND_ON          = 4'd0;
  localparam logic [3:0] KIND_OFF         = 4'd1;
  localparam logic [3:0] KIND_ORIGIN      = 4'd2;
  localparam logic [3:0] KIND_ANGLE       = 4'd3;
  localparam logic [3:0] KIND_ANGLE_NA    = 4'd4;
  localparam logic [3:0] KIND_RPM         = 4'd5;
  localparam logic [3:0] KIND_ACC         = 4'd6;
  localparam logic [3:0] KIND_DEC         = 4'd7;
  localparam logic [3:0] KIND_READ_SINGLE = 4'd8;
  localparam logic [3:0] KIND_READ_MULTI  = 4'd9;

  // configuration register indexes
  localparam logic [3:0] CFG_DEVICE_ID       = 4'd0;
  localparam logic [3:0] CFG_COUNTS_PER_TURN = 4'd1;
  localparam logic [3:0] CFG_GEAR_RATIO      = 4'd2;
  localparam logic [3:0] CFG_CRC_HIGH_FIRST  = 4'd3;

  localparam logic [7:0] FUNC_WRITE = 8'h06;
  localparam logic [7:0] FUNC_READ  = 8'h03;

  localparam logic [7:0] REG_POWER       = 8'h10;
  localparam logic [7:0] REG_ORIGIN      = 8'h32;
  localparam logic [7:0] REG_ANGLE       = 8'h82;
  localparam logic [7:0] REG_ANGLE_NA    = 8'h81;
  localparam logic [7:0] REG_SPEED       = 8'h2E;
  localparam logic [7:0] REG_ACC         = 8'h27;
  localparam logic [7:0] REG_DEC         = 8'h28;
  localparam logic [7:0] REG_READ_SINGLE = 8'h15;
  localparam logic [7:0] REG_READ_MULTI  = 8'h13;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int FRAME_LEN = 10;
  localparam int DATA_LEN  = 8;

  // 36000 = 32 * 1125: shift by five, then divide by 1125 via reciprocal
  localparam int DIV_SHIFT   = 5;
  localparam int DIV_ODD     = 1125;
  localparam int RECIP_SHIFT = 42;
  localparam logic [31:0] RECIP     = 32'((64'd1 << RECIP_SHIFT) / DIV_ODD);
  localparam logic [41:0] SAT_LIMIT = 42'(64'(DIV_ODD) << 31);

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [23:0] angle_centideg;
    logic signed [31:0] set_value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  device_id;
    logic [15:0] counts_per_turn;
    logic [9:0]  gear_ratio;
    logic        crc_high_first;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] set_value;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic        neg;
    logic        sat;
    logic [30:0] mag;
  } scl_t;

  typedef struct packed {
    logic ld_ready;
    logic busy;
  } ser_stat_t;

  typedef struct packed {
    logic [7:0] func;
    logic [7:0] reg_num;
  } cmd_t;

  function automatic logic kind_valid(logic [3:0] kind);
    return kind <= KIND_READ_MULTI;
  endfunction

  function automatic cmd_t cmd_lookup(logic [3:0] kind);
    cmd_t c;
    c.func    = FUNC_WRITE;
    c.reg_num = REG_POWER;
    unique case (kind) inside
      KIND_ON, KIND_OFF: c.reg_num = REG_POWER;
      KIND_ORIGIN:       c.reg_num = REG_ORIGIN;
      KIND_ANGLE:        c.reg_num = REG_ANGLE;
      KIND_ANGLE_NA:     c.reg_num = REG_ANGLE_NA;
      KIND_RPM:          c.reg_num = REG_SPEED;
      KIND_ACC:          c.reg_num = REG_ACC;
      KIND_DEC:          c.reg_num = REG_DEC;
      KIND_READ_SINGLE: begin
        c.func    = FUNC_READ;
        c.reg_num = REG_READ_SINGLE;
      end
      KIND_READ_MULTI: begin
        c.func    = FUNC_READ;
        c.reg_num = REG_READ_MULTI;
      end
      default: c.reg_num = REG_POWER;
    endcase
    return c;
  endfunction

  // one byte of the reflected crc16
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ design/mcfb_scale.sv @@
module mcfb_scale (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  mcfb_pkg::in_word_t in_data,
  input  mcfb_pkg::cfg_t     cfg,
  output logic               out_valid,
  output mcfb_pkg::scl_t     out_data
);

  logic [8:1]      v_r;
  mcfb_pkg::side_t sd_r [1:8];
  logic [8:3]      neg_r;
  logic [8:3]      sat_r;

  logic signed [39:0] p1_r;
  logic signed [49:0] p2_r;
  logic [41:0]        n3_r, n4_r, n5_r;
  logic [63:0]        pl4_r, pl5_r;
  logic [9:0]         nh4_r;
  logic [41:0]        ph5_r;
  logic [30:0]        q6_r, q7_r, q8_r;
  logic [11:0]        n6_r, n7_r, t7_r;

  logic signed [40:0] p1_nxt;
  logic signed [50:0] p2_nxt;
  logic [49:0]        mag_w;
  logic [43:0]        n_w;
  logic [63:0]        pl4_nxt;
  logic [41:0]        ph5_nxt;
  logic [73:0]        sum_w;
  logic [23:0]        t_w;
  logic [11:0]        r_w;
  logic               corr_w;

  always_comb begin
    p1_nxt  = in_data.angle_centideg * $signed({1'b0, cfg.counts_per_turn});
    p2_nxt  = p1_r * $signed({1'b0, cfg.gear_ratio});
    mag_w   = p2_r[49] ? (50'd0 - p2_r) : p2_r;
    n_w     = mag_w[48:mcfb_pkg::DIV_SHIFT];
    pl4_nxt = 64'(n3_r[31:0]) * 64'(mcfb_pkg::RECIP);
    ph5_nxt = 42'(nh4_r) * 42'(mcfb_pkg::RECIP);
    sum_w   = {ph5_r, 32'd0} + 74'(pl5_r);
    t_w     = q6_r[11:0] * 12'(mcfb_pkg::DIV_ODD);
    // remainder stays below twice the divisor, twelve bits are enough
    r_w     = n7_r - t7_r;
    corr_w  = r_w >= 12'(mcfb_pkg::DIV_ODD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[7:1], in_valid && mcfb_pkg::kind_valid(in_data.kind)};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[1] <= '{kind: in_data.kind, set_value: in_data.set_value};
      for (int i = 2; i <= 8; i++) begin
        sd_r[i] <= sd_r[i-1];
      end
      p1_r <= p1_nxt[39:0];
      p2_r <= p2_nxt[49:0];
      // stage 3: magnitude, saturation test
      neg_r[3] <= p2_r[49];
      sat_r[3] <= n_w >= 44'(mcfb_pkg::SAT_LIMIT);
      n3_r     <= n_w[41:0];
      for (int i = 4; i <= 8; i++) begin
        neg_r[i] <= neg_r[i-1];
        sat_r[i] <= sat_r[i-1];
      end
      // stages 4 and 5: reciprocal product in two halves
      pl4_r <= pl4_nxt;
      nh4_r <= n3_r[41:32];
      n4_r  <= n3_r;
      ph5_r <= ph5_nxt;
      pl5_r <= pl4_r;
      n5_r  <= n4_r;
      // stage 6: quotient estimate, low or exact
      q6_r <= sum_w[72:42];
      n6_r <= n5_r[11:0];
      // stage 7 and 8: remainder check and correction
      t7_r <= t_w[11:0];
      q7_r <= q6_r;
      n7_r <= n6_r;
      q8_r <= q7_r + 31'(corr_w);
    end
  end

  assign out_valid     = v_r[8];
  assign out_data.side = sd_r[8];
  assign out_data.neg  = neg_r[8];
  assign out_data.sat  = sat_r[8];
  assign out_data.mag  = q8_r;

endmodule

@@ design/mcfb_serial.sv @@
module mcfb_serial (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  mcfb_pkg::scl_t      in_data,
  input  mcfb_pkg::cfg_t      cfg,
  output mcfb_pkg::ser_stat_t stat,
  output logic                out_valid,
  input  logic                out_stall,
  output mcfb_pkg::out_word_t out_data
);

  logic                ldv_r, ldv_nxt;
  logic [63:0]         ldf_r, ldf_nxt;
  logic                busy_r, busy_nxt;
  logic [63:0]         sh_r, sh_nxt;
  logic [15:0]         crc_r, crc_nxt;
  logic [3:0]          idx_r, idx_nxt;
  logic                ov_r, ov_nxt;
  mcfb_pkg::out_word_t ob_r, ob_nxt;

  logic          ocan, emit, last_emit, take, ld_ready;
  logic [31:0]   cnt_w, word_w;
  logic [7:0]    byte_w;
  mcfb_pkg::cmd_t cmd_w;

  always_comb begin
    if (in_data.sat) begin
      cnt_w = in_data.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (in_data.neg) begin
      cnt_w = 32'd0 - {1'b0, in_data.mag};
    end else begin
      cnt_w = {1'b0, in_data.mag};
    end
    case (in_data.side.kind) inside
      mcfb_pkg::KIND_ON, mcfb_pkg::KIND_ORIGIN:             word_w = 32'd1;
      mcfb_pkg::KIND_OFF:                                   word_w = 32'd0;
      mcfb_pkg::KIND_ANGLE, mcfb_pkg::KIND_ANGLE_NA:        word_w = cnt_w;
      mcfb_pkg::KIND_RPM, mcfb_pkg::KIND_ACC, mcfb_pkg::KIND_DEC:
        word_w = in_data.side.set_value;
      mcfb_pkg::KIND_READ_SINGLE, mcfb_pkg::KIND_READ_MULTI: word_w = 32'd2;
      default:                                              word_w = 32'd0;
    endcase
    cmd_w = mcfb_pkg::cmd_lookup(in_data.side.kind);

    ocan      = !ov_r || !out_stall;
    emit      = busy_r && ocan;
    last_emit = emit && (idx_r == 4'(mcfb_pkg::FRAME_LEN - 1));
    // next frame loads in the cycle the last byte goes out
    take      = !busy_r || last_emit;
    ld_ready  = !ldv_r || take;

    if (idx_r < 4'(mcfb_pkg::DATA_LEN)) begin
      byte_w = sh_r[63:56];
    end else if ((idx_r == 4'(mcfb_pkg::DATA_LEN)) == cfg.crc_high_first) begin
      byte_w = crc_r[15:8];
    end else begin
      byte_w = crc_r[7:0];
    end

    ldv_nxt  = ldv_r;
    ldf_nxt  = ldf_r;
    busy_nxt = busy_r;
    sh_nxt   = sh_r;
    crc_nxt  = crc_r;
    idx_nxt  = idx_r;
    ov_nxt   = ov_r;
    ob_nxt   = ob_r;

    if (ld_ready) begin
      ldv_nxt = in_valid;
      ldf_nxt = {cfg.device_id, cmd_w.func, 8'h00, cmd_w.reg_num, word_w};
    end
    if (emit) begin
      idx_nxt = idx_r + 4'd1;
      if (idx_r < 4'(mcfb_pkg::DATA_LEN)) begin
        sh_nxt  = {sh_r[55:0], 8'h00};
        crc_nxt = mcfb_pkg::crc_byte(crc_r, byte_w);
      end
    end
    if (take) begin
      busy_nxt = ldv_r;
      if (ldv_r) begin
        sh_nxt  = ldf_r;
        crc_nxt = mcfb_pkg::CRC_INIT;
        idx_nxt = 4'd0;
      end
    end
    if (ocan) begin
      ov_nxt            = emit;
      ob_nxt.frame_byte = byte_w;
      ob_nxt.last_byte  = last_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ldv_r  <= 1'b0;
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
      idx_r  <= 4'd0;
    end else begin
      ldv_r  <= ldv_nxt;
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ldf_r <= ldf_nxt;
    sh_r  <= sh_nxt;
    crc_r <= crc_nxt;
    ob_r  <= ob_nxt;
  end

  assign stat.ld_ready = ld_ready;
  assign stat.busy     = busy_r;
  assign out_valid     = ov_r;
  assign out_data      = ob_r;

endmodule

@@ design/motor_command_frame_builder.sv @@
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   mcfb_pkg::in_word_t, one motor command
// out      output     out_valid / out_stall mcfb_pkg::out_word_t, one frame byte
// cfg      input      cfg_we                cfg_index, cfg_wdata
//
// each command gives ten byte words, one per cycle while out_stall is low; the byte
// serializer with its crc update sets the pace at which commands are taken, and its
// load buffer holds the next command while a frame goes out; the first byte passes
// eight scaling stages, the load buffer, the shifter and the output register
// commands of an unused kind are taken and give no bytes
// rst_n is synchronous: clears all valid bits and loads the register reset values
// out_stall holds the byte on the port; the pipeline runs on until its last stage is full

module motor_command_frame_builder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mcfb_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mcfb_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);

  mcfb_pkg::cfg_t      cfg_r, cfg_nxt;
  mcfb_pkg::ser_stat_t ser_stat;
  mcfb_pkg::scl_t      scl_data;
  logic                scl_valid;
  logic                pipe_en;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        mcfb_pkg::CFG_DEVICE_ID:       cfg_nxt.device_id       = cfg_wdata[7:0];
        mcfb_pkg::CFG_COUNTS_PER_TURN: cfg_nxt.counts_per_turn = cfg_wdata;
        mcfb_pkg::CFG_GEAR_RATIO:      cfg_nxt.gear_ratio      = cfg_wdata[9:0];
        mcfb_pkg::CFG_CRC_HIGH_FIRST:  cfg_nxt.crc_high_first  = cfg_wdata[0];
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_id       <= 8'd0;
      cfg_r.counts_per_turn <= 16'd0;
      cfg_r.gear_ratio      <= 10'd0;
      cfg_r.crc_high_first  <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // whole scaling pipe advances unless its last word waits on the serializer
  assign pipe_en  = !scl_valid || ser_stat.ld_ready;
  assign in_stall = !pipe_en;

  mcfb_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .out_valid (scl_valid),
    .out_data  (scl_data)
  );

  mcfb_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (scl_valid),
    .in_data   (scl_data),
    .cfg       (cfg_r),
    .stat      (ser_stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_byte_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_byte |=> out_valid)
    else $error("frame broken off before its last byte");

  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    !ser_stat.busy |-> !out_valid || out_data.last_byte)
    else $error("serializer idle while a middle byte is pending");

  a_busy_emits: assert property (@(posedge clk) disable iff (!rst_n)
    ser_stat.busy && !out_valid |=> out_valid)
    else $error("busy serializer left the output empty");

endmodule

@@ bench/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 10;
  localparam int DRAIN_CYCLES    = 40;
  localparam int ITEMS_PER_PHASE = 20;
  localparam int RANDOM_PHASES   = 6;
  localparam int CYCLE_LIMIT     = 100000;

  localparam longint DEG_SCALE = 36000;
  localparam longint COUNT_MAX = 64'sd2147483647;
  localparam longint COUNT_MIN = -64'sd2147483648;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_t;

  class frame_scoreboard_t;
    mcfb_pkg::cfg_t      regs;
    mcfb_pkg::out_word_t expected_bytes[$];
    int                  errors;

    function new();
      regs.device_id       = '0;
      regs.counts_per_turn = '0;
      regs.gear_ratio      = '0;
      regs.crc_high_first  = 1'b1;
      errors               = 0;
    endfunction

    function void write_reg(logic [3:0] idx, logic [15:0] val);
      case (idx)
        mcfb_pkg::CFG_DEVICE_ID:       regs.device_id       = val[7:0];
        mcfb_pkg::CFG_COUNTS_PER_TURN: regs.counts_per_turn = val;
        mcfb_pkg::CFG_GEAR_RATIO:      regs.gear_ratio      = val[9:0];
        mcfb_pkg::CFG_CRC_HIGH_FIRST:  regs.crc_high_first  = val[0];
        default: ;
      endcase
    endfunction

    // exact product, truncated toward zero, clamped to 32-bit signed
    function logic [31:0] angle_count(logic signed [23:0] ang);
      longint a, c, g, q;
      a = ang;
      c = regs.counts_per_turn;
      g = regs.gear_ratio;
      q = (a * c * g) / DEG_SCALE;
      if (q > COUNT_MAX) return 32'h7FFF_FFFF;
      if (q < COUNT_MIN) return 32'h8000_0000;
      return q[31:0];
    endfunction

    function void note_command(mcfb_pkg::in_word_t w);
      logic [7:0]          fb[mcfb_pkg::FRAME_LEN];
      logic [7:0]          func;
      logic [7:0]          reg_num;
      logic [31:0]         data;
      logic [15:0]         crc;
      mcfb_pkg::out_word_t ob;
      func = mcfb_pkg::FUNC_WRITE;
      case (w.kind)
        mcfb_pkg::KIND_ON: begin
          reg_num = mcfb_pkg::REG_POWER;
          data    = 32'd1;
        end
        mcfb_pkg::KIND_OFF: begin
          reg_num = mcfb_pkg::REG_POWER;
          data    = 32'd0;
        end
        mcfb_pkg::KIND_ORIGIN: begin
          reg_num = mcfb_pkg::REG_ORIGIN;
          data    = 32'd1;
        end
        mcfb_pkg::KIND_ANGLE: begin
          reg_num = mcfb_pkg::REG_ANGLE;
          data    = angle_count(w.angle_centideg);
        end
        mcfb_pkg::KIND_ANGLE_NA: begin
          reg_num = mcfb_pkg::REG_ANGLE_NA;
          data    = angle_count(w.angle_centideg);
        end
        mcfb_pkg::KIND_RPM: begin
          reg_num = mcfb_pkg::REG_SPEED;
          data    = w.set_value;
        end
        mcfb_pkg::KIND_ACC: begin
          reg_num = mcfb_pkg::REG_ACC;
          data    = w.set_value;
        end
        mcfb_pkg::KIND_DEC: begin
          reg_num = mcfb_pkg::REG_DEC;
          data    = w.set_value;
        end
        mcfb_pkg::KIND_READ_SINGLE: begin
          func    = mcfb_pkg::FUNC_READ;
          reg_num = mcfb_pkg::REG_READ_SINGLE;
          data    = 32'd2;
        end
        mcfb_pkg::KIND_READ_MULTI: begin
          func    = mcfb_pkg::FUNC_READ;
          reg_num = mcfb_pkg::REG_READ_MULTI;
          data    = 32'd2;
        end
        default: return;  // unused kinds give no frame
      endcase
      fb[0] = regs.device_id;
      fb[1] = func;
      fb[2] = 8'h00;
      fb[3] = reg_num;
      fb[4] = data[31:24];
      fb[5] = data[23:16];
      fb[6] = data[15:8];
      fb[7] = data[7:0];
      crc = mcfb_pkg::CRC_INIT;
      for (int k = 0; k < mcfb_pkg::DATA_LEN; k++) begin
        crc = crc ^ {8'h00, fb[k]};
        for (int b = 0; b < 8; b++) begin
          crc = crc[0] ? ((crc >> 1) ^ mcfb_pkg::CRC_POLY) : (crc >> 1);
        end
      end
      fb[8] = regs.crc_high_first ? crc[15:8] : crc[7:0];
      fb[9] = regs.crc_high_first ? crc[7:0] : crc[15:8];
      for (int k = 0; k < mcfb_pkg::FRAME_LEN; k++) begin
        ob.frame_byte = fb[k];
        ob.last_byte  = (k == mcfb_pkg::FRAME_LEN - 1);
        expected_bytes.push_back(ob);
      end
    endfunction

    function void check_byte(mcfb_pkg::out_word_t got);
      mcfb_pkg::out_word_t want;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual byte %h last %b",
                 $time, got.frame_byte, got.last_byte);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.frame_byte !== want.frame_byte) begin
        $display("%0t: frame_byte mismatch: expected %h, actual %h",
                 $time, want.frame_byte, got.frame_byte);
        errors++;
      end
      if (got.last_byte !== want.last_byte) begin
        $display("%0t: last_byte mismatch: expected %b, actual %b",
                 $time, want.last_byte, got.last_byte);
        errors++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  mcfb_pkg::in_word_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  mcfb_pkg::out_word_t out_data;
  logic                cfg_we    = 1'b0;
  logic [3:0]          cfg_index = mcfb_pkg::CFG_DEVICE_ID;
  logic [15:0]         cfg_wdata = '0;

  frame_scoreboard_t sb;
  int                burst_left = 0;
  stall_mode_t       stall_mode = STALL_NONE;
  int                stall_phase_left = 0;
  int unsigned       cycle_count = 0;

  motor_command_frame_builder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // receiver stalls in stretches of varying density
  always @(posedge clk) begin
    if (stall_phase_left == 0) begin
      stall_mode       <= stall_mode_t'($urandom_range(0, 3));
      stall_phase_left <= $urandom_range(20, 80);
    end else begin
      stall_phase_left <= stall_phase_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ($urandom_range(0, 7) == 0) ? ~out_stall : out_stall;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_byte(out_data);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic send_command(input mcfb_pkg::in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    sb.note_command(w);
    burst_left--;
  endtask

  task automatic send_fields(input logic [3:0] kind, input logic [23:0] ang,
                             input logic [31:0] val);
    mcfb_pkg::in_word_t w;
    w.kind           = kind;
    w.angle_centideg = ang;
    w.set_value      = val;
    send_command(w);
  endtask

  // let the last frame and any unused-kind word clear the pipeline
  task automatic drain_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic program_regs(input logic [15:0] dev, input logic [15:0] cpt,
                              input logic [15:0] gr, input logic [15:0] crc_hf,
                              input bit junk);
    write_reg(mcfb_pkg::CFG_DEVICE_ID, dev);
    write_reg(mcfb_pkg::CFG_COUNTS_PER_TURN, cpt);
    write_reg(mcfb_pkg::CFG_GEAR_RATIO, gr);
    write_reg(mcfb_pkg::CFG_CRC_HIGH_FIRST, crc_hf);
    if (junk) begin
      write_reg(4'($urandom_range(mcfb_pkg::CFG_CRC_HIGH_FIRST + 1, 15)), 16'($urandom));
    end
    cfg_we <= 1'b0;
  endtask

  function automatic mcfb_pkg::in_word_t random_command();
    mcfb_pkg::in_word_t w;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      w.kind = 4'($urandom_range(mcfb_pkg::KIND_READ_MULTI + 1, 15));
    end else if (pick < 45) begin
      w.kind = $urandom_range(0, 1) ? mcfb_pkg::KIND_ANGLE : mcfb_pkg::KIND_ANGLE_NA;
    end else begin
      w.kind = 4'($urandom_range(mcfb_pkg::KIND_ON, mcfb_pkg::KIND_READ_MULTI));
    end
    // small angles keep most counts inside the 32-bit range
    if ($urandom_range(0, 2) == 0) begin
      w.angle_centideg = 24'(int'($urandom_range(0, 200000)) - 100000);
    end else begin
      w.angle_centideg = 24'($urandom);
    end
    w.set_value = $urandom;
    return w;
  endfunction

  initial begin
    mcfb_pkg::in_word_t w;
    int                 sent;
    logic [15:0]        cpt, gr;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero scale, crc high byte first, every kind incl. unused
    for (int k = 0; k < 16; k++) begin
      send_fields(4'(k), 24'($urandom), $urandom);
    end
    drain_idle();

    // widest settings, low byte first; angle counts saturate both ways
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE, 1'b1);
    send_fields(mcfb_pkg::KIND_ANGLE, 24'h7FFFFF, $urandom);
    send_fields(mcfb_pkg::KIND_ANGLE_NA, 24'h800000, $urandom);
    send_fields(mcfb_pkg::KIND_ANGLE, 24'h000000, $urandom);
    send_fields(mcfb_pkg::KIND_RPM, 24'($urandom), 32'h7FFF_FFFF);
    send_fields(mcfb_pkg::KIND_ACC, 24'($urandom), 32'h8000_0000);
    send_fields(mcfb_pkg::KIND_DEC, 24'($urandom), 32'h0000_0000);
    drain_idle();

    // unit scale: truncation toward zero on negative angles
    program_regs(16'h0000, 16'd1, 16'd1, 16'd1, 1'b0);
    send_fields(mcfb_pkg::KIND_ANGLE, -24'sd35999, $urandom);
    send_fields(mcfb_pkg::KIND_ANGLE_NA, -24'sd36001, $urandom);
    send_fields(mcfb_pkg::KIND_ANGLE, 24'sd36000, $urandom);
    drain_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0:       cpt = 16'h0000;
        1:       cpt = 16'hFFFF;
        default: cpt = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       gr = 16'h0000;
        1:       gr = 16'h03FF;
        default: gr = 16'($urandom);
      endcase
      program_regs(16'($urandom), cpt, gr, 16'($urandom), 1'($urandom_range(0, 1)));
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        w = random_command();
        send_command(w);
        if (w.kind <= mcfb_pkg::KIND_READ_MULTI) sent++;
      end
      drain_idle();
    end

    if (sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/mcfb_pkg.sv
design/mcfb_scale.sv
design/mcfb_serial.sv
design/motor_command_frame_builder.sv
bench/tb_top.sv
